// File: src/lcfr_pkg.sv
// ----------------------------------------------------------------------------
// lcfr_pkg
// shared request codes, widths and types of the frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcfr_pkg;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  localparam logic [ReqW-1:0] REQ_BYTE    = 3'd0;
  localparam logic [ReqW-1:0] REQ_ARM     = 3'd1;
  localparam logic [ReqW-1:0] REQ_TIMEOUT = 3'd2;
  localparam logic [ReqW-1:0] REQ_RELEASE = 3'd3;
  localparam logic [ReqW-1:0] REQ_READ    = 3'd4;

  localparam logic [StatusW-1:0] STATUS_NONE    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OK      = 2'd1;
  localparam logic [StatusW-1:0] STATUS_SUM_ERR = 2'd2;
  localparam logic [StatusW-1:0] STATUS_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [ByteW-1:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic               busy;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   count;
  } resp_t;

  typedef struct packed {
    logic             en;
    logic [ByteW-1:0] addr;
    logic [ByteW-1:0] data;
  } wr_req_t;

endpackage

// File: src/lcfr_ram.sv
// ----------------------------------------------------------------------------
// lcfr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lcfr_ctrl.sv
// ----------------------------------------------------------------------------
// lcfr_ctrl
// frame phase sequencer with running checksum and buffer write pointer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfr_ctrl #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  lcfr_pkg::req_t   req_i,
  output lcfr_pkg::resp_t  resp_o,
  output lcfr_pkg::wr_req_t wr_o
);
  import lcfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_OK,
    PH_ERR,
    PH_TIME
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] exp_q, exp_d;
  logic [ByteW-1:0] wp_q, wp_d;
  logic [ByteW-1:0] wp_inc;
  logic             wp_in_range;

  assign wp_inc      = wp_q + 8'd1;
  assign wp_in_range = {1'b0, wp_q} < 9'(BUFFER_DEPTH);

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    exp_d   = exp_q;
    wp_d    = wp_q;
    wr_o    = '0;
    wr_o.addr = wp_q;
    wr_o.data = req_i.rx_byte;
    if (take_i) begin
      unique case (req_i.req_type)
        REQ_BYTE: begin
          unique case (phase_q)
            PH_LEN: begin
              sum_d   = req_i.rx_byte;
              wp_d    = '0;
              exp_d   = req_i.rx_byte - 8'd1;
              phase_d = (req_i.rx_byte != 8'd1) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
              wr_o.en = wp_in_range;
              wp_d    = wp_inc;
              sum_d   = sum_q + req_i.rx_byte;
              if (wp_inc >= exp_q) begin
                phase_d = PH_SUM;
              end
            end
            PH_SUM: begin
              phase_d = (req_i.rx_byte == sum_q) ? PH_OK : PH_ERR;
            end
            default: begin
            end
          endcase
        end
        REQ_ARM: begin
          phase_d = PH_LEN;
          sum_d   = '0;
          wp_d    = '0;
        end
        REQ_TIMEOUT: begin
          if (phase_q == PH_LEN || phase_q == PH_DATA || phase_q == PH_SUM) begin
            phase_d = PH_TIME;
          end
        end
        REQ_RELEASE: begin
          phase_d = PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    resp_o.busy  = (phase_d != PH_IDLE);
    resp_o.count = wp_d;
    unique case (phase_d)
      PH_OK:   resp_o.status = STATUS_OK;
      PH_ERR:  resp_o.status = STATUS_SUM_ERR;
      PH_TIME: resp_o.status = STATUS_TIMEOUT;
      default: resp_o.status = STATUS_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sum_q   <= '0;
      exp_q   <= '0;
      wp_q    <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      exp_q   <= exp_d;
      wp_q    <= wp_d;
    end
  end

endmodule

// File: src/length_checksum_frame_receiver.sv
// ----------------------------------------------------------------------------
// length_checksum_frame_receiver
// length prefixed frame receiver with additive 8-bit checksum
// ----------------------------------------------------------------------------
// requests arrive as transfers on the s_axis channel: tuser carries the
// request kind (byte, arm, timeout, release, read), tdata the received byte
// and the buffer index. every request gives exactly one result transfer on
// the m_axis channel with busy, reply status, payload count and read data.
// the result is registered and becomes valid in the cycle after the request transfer.
// throughput is one request per cycle unless the result stalls: the payload
// buffer has one write and one read port, so a byte write and a later buffer
// read never compete for the same port.
// payload bytes live in a BUFFER_DEPTH entry ram; read data comes out of the
// ram read register and is shown with the registered result.
// reset puts the receiver in idle with an empty frame; the buffer keeps its
// contents and needs no clearing pass.
// when the result is not taken, s_axis_tready drops and both the result
// register and the ram read register hold until the transfer completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_checksum_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // rx_byte [7:0], read_index [15:8]
  input  logic [lcfr_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type [2:0]
  input  logic [lcfr_pkg::ReqW-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // busy_res [0], reply_status [2:1], payload_count [10:3], read_data [18:11]
  output logic [lcfr_pkg::OutDataW-1:0]  m_axis_tdata
);
  import lcfr_pkg::*;

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic             take;
  req_t             req;
  resp_t            resp;
  wr_req_t          wr;
  logic [ByteW-1:0] read_index;
  logic             rd_hit;
  logic [ByteW-1:0] ram_rdata;

  logic             out_valid_q;
  resp_t            resp_q;
  logic             rd_sel_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign req.req_type = s_axis_tuser;
  assign req.rx_byte  = s_axis_tdata[ByteW-1:0];
  assign read_index   = s_axis_tdata[2*ByteW-1:ByteW];
  assign rd_hit       = take && (s_axis_tuser == REQ_READ)
                        && ({1'b0, read_index} < 9'(BUFFER_DEPTH));

  lcfr_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .req_i (req),
    .resp_o(resp),
    .wr_o  (wr)
  );

  lcfr_ram #(
    .WIDTH(ByteW),
    .DEPTH(BUFFER_DEPTH)
  ) u_buffer (
    .clk_i  (clk_i),
    .we_i   (wr.en),
    .waddr_i(wr.addr[AddrW-1:0]),
    .wdata_i(wr.data),
    .re_i   (rd_hit),
    .raddr_i(read_index[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rd_sel_q    <= 1'b0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        rd_sel_q    <= rd_hit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      resp_q <= resp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, (rd_sel_q ? ram_rdata : 8'd0),
                          resp_q.count, resp_q.status, resp_q.busy};

endmodule

// File: src/lcfr_checker.sv
// ----------------------------------------------------------------------------
// lcfr_checker
// port level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [lcfr_pkg::ReqW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lcfr_pkg::OutDataW-1:0] m_axis_tdata
);
  import lcfr_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // every request transfer gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("result missing after request");

  // arm opens an empty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tuser == REQ_ARM |=>
      m_axis_tdata[0] && m_axis_tdata[2:1] == STATUS_NONE && m_axis_tdata[10:3] == 8'd0)
    else $error("arm result wrong");

  // only read requests return buffer data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tuser != REQ_READ |=> m_axis_tdata[18:11] == 8'd0)
    else $error("read data on non read request");

  // an idle receiver reports no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == STATUS_NONE)
    else $error("status while idle");

endmodule

bind length_checksum_frame_receiver lcfr_checker u_lcfr_checker (.*);
